// ===== rtl/s256_pkg.sv =====
package s256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic       append;
		logic [7:0] byte_val;
		logic       load;
		logic       step;
		logic [5:0] round;
	} core_cmd_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== rtl/s256_if.sv =====
interface s256_msg_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface s256_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== rtl/s256_core.sv =====
module s256_core (
	input  logic                clk,
	input  s256_pkg::core_cmd_t cmd,
	input  s256_pkg::hash_t     hash,
	output s256_pkg::hash_t     work
);

	logic [511:0]        win_q;
	s256_pkg::hash_t     work_q;
	s256_pkg::word_t     w0, w1, w9, w14, w_new, t1, t2, ch, maj;

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];

	assign w_new = s256_pkg::small_sigma1(w14) + w9 + s256_pkg::small_sigma0(w1) + w0;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + s256_pkg::big_sigma1(work_q[4]) + ch +
		s256_pkg::ROUND_K[cmd.round] + w0;
	assign t2  = s256_pkg::big_sigma0(work_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			win_q <= {win_q[503:0], cmd.byte_val};
		end else if (cmd.step) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= hash;
		end else if (cmd.step) begin
			work_q <= {work_q[6], work_q[5], work_q[4], work_q[3] + t1,
				work_q[2], work_q[1], work_q[0], t1 + t2};
		end
	end

	assign work = work_q;

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Channel  Role  Payload                                  Beat
// msg      sink  op, data_byte                            one message byte or a finish
// dig      src   digest_word, word_index, last_word       one digest word, eight per finish
//
// An absorb beat appends one byte; the 64th byte of a block starts a compression (64 rounds, one fold).
// A finish beat pads one byte per cycle between compressions up to the length field, writes eight
// length bytes, and compresses once or twice, then offers eight digest beats, one per accepted cycle.
// The round unit, used once per round, sets the block time; msg is not ready meanwhile.
// Reset loads the initial hash values and clears the byte and length counts at once.
// A stall on dig holds the current digest word until it is taken.
module sha256_byte_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	s256_msg_if.sink          msg,
	s256_dig_if.source        dig
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FOLD  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic [5:0]          fill_q;
	logic [60:0]         count_q;
	s256_pkg::hash_t     hash_q;
	logic                first_q;
	logic                final_q;
	logic                resume_pad_q;
	logic [5:0]          round_q;
	logic [2:0]          word_q;

	s256_pkg::core_cmd_t cmd;
	s256_pkg::hash_t     work;
	logic [63:0]         len_bits;
	logic [63:0]         len_shift;
	logic                msg_acc;
	logic                dig_acc;
	logic                pad_done;

	assign msg_acc   = msg.valid && msg.ready;
	assign dig_acc   = dig.valid && dig.ready;
	assign len_bits  = {count_q, 3'b000};
	assign len_shift = len_bits >> {~fill_q[2:0], 3'b000};
	assign pad_done  = !first_q && (fill_q == s256_pkg::LEN_FILL);

	always_comb begin
		cmd          = '0;
		cmd.round    = round_q;
		cmd.byte_val = msg.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				cmd.append = msg_acc && !msg.op;
				cmd.load   = msg_acc && !msg.op && (fill_q == 6'd63);
			end
			ST_PAD: begin
				cmd.append   = !pad_done;
				cmd.byte_val = first_q ? s256_pkg::PAD_BYTE : 8'h00;
				cmd.load     = !pad_done && (fill_q == 6'd63);
			end
			ST_LEN: begin
				cmd.append   = 1'b1;
				cmd.byte_val = len_shift[7:0];
				cmd.load     = (fill_q == 6'd63);
			end
			ST_ROUND: begin
				cmd.step = 1'b1;
			end
			default: begin
			end
		endcase
	end

	s256_core u_core (
		.clk  (clk),
		.cmd  (cmd),
		.hash (hash_q),
		.work (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			count_q      <= '0;
			hash_q       <= s256_pkg::INIT_HASH;
			first_q      <= 1'b0;
			final_q      <= 1'b0;
			resume_pad_q <= 1'b0;
			round_q      <= '0;
			word_q       <= '0;
		end else begin
			if (cmd.append) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.load) begin
				state_q <= ST_ROUND;
				round_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc && !msg.op) begin
						count_q      <= count_q + 61'd1;
						final_q      <= 1'b0;
						resume_pad_q <= 1'b0;
					end else if (msg_acc) begin
						state_q <= ST_PAD;
						first_q <= 1'b1;
					end
				end
				ST_PAD: begin
					first_q      <= 1'b0;
					final_q      <= 1'b0;
					resume_pad_q <= 1'b1;
					if (pad_done) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					final_q <= 1'b1;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + work[i];
					end
					if (final_q) begin
						state_q <= ST_OUT;
						word_q  <= '0;
					end else if (resume_pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						word_q <= word_q + 3'd1;
						hash_q <= {hash_q[0], hash_q[7:1]};
						if (word_q == 3'd7) begin
							state_q <= ST_IDLE;
							hash_q  <= s256_pkg::INIT_HASH;
							fill_q  <= '0;
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign msg.ready       = (state_q == ST_IDLE);
	assign dig.valid       = (state_q == ST_OUT);
	assign dig.digest_word = hash_q[0];
	assign dig.word_index  = word_q;
	assign dig.last_word   = (word_q == 3'd7);

	assert property (@(posedge clk) disable iff (!arst_n) msg.ready |-> !dig.valid)
		else $error("input accepted while a digest is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig.last_word) |=> (msg.ready && fill_q == 6'd0 && count_q == 61'd0))
		else $error("message state not restarted after the last digest beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (fill_q[5:3] == 3'b111))
		else $error("length field written outside the block tail");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_ROUND) |-> (round_q == 6'd0))
		else $error("compression started at a nonzero round");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND && $past(round_q) == 6'd63))
		else $error("fold reached before the last round");

endmodule

// ===== tb/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} hash_op_e;

	typedef enum int {
		PACE_FULL,
		PACE_HALF,
		PACE_QUARTER,
		PACE_MOSTLY
	} sink_pace_e;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZEROS,
		FILL_ONES
	} fill_style_e;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        last;
	} digest_beat_t;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int HOLD_OFF_CYCLES = 400;

	logic clk;
	logic arst_n;

	s256_msg_if msg_bus ();
	s256_dig_if dig_bus ();

	sha256_byte_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_bus),
		.dig    (dig_bus)
	);

	logic [31:0] hash_st [8];
	logic [7:0]  block_buf [64];
	int unsigned fill_st;
	logic [60:0] count_st;

	digest_beat_t digest_q [$];

	int error_count;
	int items_sent;
	int bytes_sent;
	int messages_sent;
	int long_tails;
	int beats_checked;
	int burst_left;
	int hold_off_req;
	int hold_cnt;
	int pace_left;
	sink_pace_e pace;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_start();
		int i;
		for (i = 0; i < 8; i++)
			hash_st[i] = SHA_IV[i];
		fill_st = 0;
		count_st = '0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
		e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
		hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
	endfunction

	function automatic void sha_absorb(input logic [7:0] byte_val);
		block_buf[fill_st] = byte_val;
		fill_st++;
		count_st++;
		bytes_sent++;
		if (fill_st == 64) begin
			sha_compress();
			fill_st = 0;
		end
	endfunction

	function automatic void sha_finish();
		logic [63:0] bit_len;
		digest_beat_t beat;
		int i;
		block_buf[fill_st] = 8'h80;
		for (i = fill_st + 1; i < 64; i++)
			block_buf[i] = 8'h00;
		if (fill_st >= 56) begin
			sha_compress();
			for (i = 0; i < 56; i++)
				block_buf[i] = 8'h00;
			long_tails++;
		end
		bit_len = {count_st, 3'b000};
		for (i = 0; i < 8; i++)
			block_buf[56 + i] = bit_len[63 - 8*i -: 8];
		sha_compress();
		for (i = 0; i < 8; i++) begin
			beat.word = hash_st[i];
			beat.pos = 3'(i);
			beat.last = (i == 7);
			digest_q.push_back(beat);
		end
		messages_sent++;
		sha_start();
	endfunction

	task automatic send_beat(input hash_op_e op_code, input logic [7:0] byte_val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				msg_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		msg_bus.valid <= 1'b1;
		msg_bus.op <= op_code;
		msg_bus.data_byte <= byte_val;
		do @(posedge clk); while (!msg_bus.ready);
		items_sent++;
		if (op_code == OP_FINISH)
			sha_finish();
		else
			sha_absorb(byte_val);
	endtask

	task automatic send_message(input int len, input fill_style_e fill_style);
		logic [7:0] byte_val;
		int i;
		for (i = 0; i < len; i++) begin
			case (fill_style)
				FILL_ZEROS: byte_val = 8'h00;
				FILL_ONES: byte_val = 8'hff;
				default: byte_val = 8'($urandom_range(0, 255));
			endcase
			send_beat(OP_ABSORB, byte_val);
		end
		send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic check_digest_beat();
		digest_beat_t want;
		beats_checked++;
		if (digest_q.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("unexpected digest beat: word %h index %0d last %b",
					dig_bus.digest_word, dig_bus.word_index, dig_bus.last_word);
		end else begin
			want = digest_q.pop_front();
			if (dig_bus.digest_word !== want.word || dig_bus.word_index !== want.pos ||
					dig_bus.last_word !== want.last) begin
				error_count++;
				if (error_count <= 10)
					$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
						want.word, want.pos, want.last, dig_bus.digest_word,
						dig_bus.word_index, dig_bus.last_word);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			dig_bus.ready <= 1'b0;
		end else begin
			if (dig_bus.valid && dig_bus.ready)
				check_digest_beat();
			if (hold_off_req != 0) begin
				hold_cnt = hold_off_req;
				hold_off_req = 0;
			end
			if (pace_left == 0) begin
				pace = sink_pace_e'($urandom_range(0, 3));
				pace_left = $urandom_range(64, 256);
			end else begin
				pace_left--;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				dig_bus.ready <= 1'b0;
			end else begin
				case (pace)
					PACE_FULL: dig_bus.ready <= 1'b1;
					PACE_HALF: dig_bus.ready <= 1'($urandom_range(0, 1));
					PACE_QUARTER: dig_bus.ready <= ($urandom_range(0, 3) == 0);
					default: dig_bus.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic test_known_vectors();
		send_beat(OP_FINISH, 8'h00);
		send_beat(OP_ABSORB, 8'h61);
		send_beat(OP_ABSORB, 8'h62);
		send_beat(OP_ABSORB, 8'h63);
		send_beat(OP_FINISH, 8'hff);
		send_beat(OP_ABSORB, 8'h00);
		send_beat(OP_FINISH, 8'h00);
		send_beat(OP_ABSORB, 8'hff);
		send_beat(OP_FINISH, 8'hff);
		send_beat(OP_ABSORB, 8'h80);
		send_beat(OP_FINISH, 8'h5a);
		send_beat(OP_FINISH, 8'ha5);
	endtask

	// About half the messages take an edge length (near empty, or on a padding or block boundary), the rest are short.
	task automatic test_random_messages();
		int edge_lens [11] = '{0, 1, 2, 55, 56, 57, 63, 64, 65, 119, 120};
		int len;
		fill_style_e style;
		while (items_sent < 410) begin
			if ($urandom_range(0, 1) == 0)
				len = edge_lens[$urandom_range(0, 10)];
			else
				len = $urandom_range(0, 20);
			style = ($urandom_range(0, 7) == 0) ? fill_style_e'($urandom_range(1, 2)) :
				FILL_RANDOM;
			send_message(len, style);
		end
	endtask

	task automatic test_output_backpressure();
		hold_off_req = HOLD_OFF_CYCLES;
		send_message(20, FILL_RANDOM);
		send_message(8, FILL_RANDOM);
		send_message(0, FILL_RANDOM);
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		msg_bus.valid = 1'b0;
		msg_bus.op = OP_ABSORB;
		msg_bus.data_byte = 8'h00;
		error_count = 0;
		items_sent = 0;
		bytes_sent = 0;
		messages_sent = 0;
		long_tails = 0;
		beats_checked = 0;
		burst_left = 0;
		hold_off_req = 0;
		hold_cnt = 0;
		pace_left = 0;
		pace = PACE_FULL;
		sha_start();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_known_vectors();
		test_random_messages();
		test_output_backpressure();

		msg_bus.valid <= 1'b0;
		wait_cycles = 0;
		while (digest_q.size() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (300) @(posedge clk);
		if (digest_q.size() != 0) begin
			$display("%0d digest words never arrived", digest_q.size());
			error_count += digest_q.size();
		end

		$display("covered %0d messages from %0d bytes in %0d beats, %0d needing an extra block",
			messages_sent, bytes_sent, items_sent, long_tails);
		$display("checked %0d digest words, including a %0d cycle output hold-off",
			beats_checked, HOLD_OFF_CYCLES);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/s256_pkg.sv
rtl/s256_if.sv
rtl/s256_core.sv
rtl/sha256_byte_stream_hasher.sv
tb/tb_sha256_byte_stream_hasher.sv
